// ----- src/sbqeq_pkg.sv -----
// ----------------------------------------------------------------------------
// Stereo biquad cascade equaliser package
// Command codes, register indexes, coefficient slots and sequencer states.
// ----------------------------------------------------------------------------
package sbqeq_pkg;

  localparam int unsigned SLOTS = 5;
  localparam logic [15:0] MIX_ONE = 16'h8000;
  localparam logic [15:0] SMOOTH_RESET = 16'd32;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_GLOBAL_BYPASS = 2'd0,
    REG_EXT_BYPASS    = 2'd1,
    REG_BAND_MASK     = 2'd2,
    REG_SMOOTHING     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_MUL,
    ST_TICK_UPD,
    ST_BAND_CHK,
    ST_BQ0,
    ST_BQ1,
    ST_BQ2,
    ST_BQ3,
    ST_BQ4,
    ST_BQ5,
    ST_BQ6,
    ST_EXT_MUL,
    ST_EXT_ADD,
    ST_GLB_MUL,
    ST_GLB_ADD
  } state_t;

endpackage

// ----- src/stereo_biquad_cascade_eq.sv -----
// ----------------------------------------------------------------------------
// Stereo biquad cascade equaliser
// Eight-band transposed direct form II cascade on one shared multiplier.
// ----------------------------------------------------------------------------
// Items arrive on the item channel (item_valid/item_ready) and carry a command.
// A sample item yields one result item on the result channel; coefficient
// write, block tick and clear items yield none. Registers are written and read
// through the APB port and should only be changed while the block is idle.
// A coefficient write or a clear is done as the item is taken. A block
// tick steps through the global, extension and band mixes, with a multiplier
// pass and then an update for each. A sample runs the biquad on every band
// with a non-zero mix: each engaged band uses the multiplier six times and
// each channel is processed in turn. All of this is done on the single
// 32x32 multiplier with its product register. Coefficients are held in a
// memory with separate write and read ports whose read is registered, so
// each coefficient is addressed in the state ahead of the one that uses it.
// The block takes a new item only when its sequencer is idle. A finished
// result waits in the output register; if the receiver stalls, the next sample
// is worked through and then holds until the register is free.
// Reset zeroes the filter delays and mixes and loads the register defaults;
// the coefficient memory is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module stereo_biquad_cascade_eq #(
  parameter int BANDS      = 8,
  parameter int BASE_BANDS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  input  logic [2:0]         coef_band,
  input  logic [2:0]         coef_slot,
  input  logic signed [20:0] coef_value,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [16:0] left_out,
  output logic signed [16:0] right_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int BW     = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int DKW    = $clog2(2 * BANDS);
  localparam int MW     = $clog2(BANDS + 2);
  localparam int CDEPTH = BANDS * sbqeq_pkg::SLOTS;
  localparam int CAW    = $clog2(CDEPTH);

  sbqeq_pkg::state_t state, state_next;

  logic              global_bypass;
  logic              extension_bypass;
  logic [7:0]        band_enable_mask;
  logic [15:0]       smoothing_factor;

  logic [15:0]       band_mix [BANDS];
  logic [15:0]       ext_mix;
  logic [15:0]       glob_mix;
  logic signed [31:0] d1 [2*BANDS];
  logic signed [31:0] d2 [2*BANDS];

  logic signed [20:0] coef_mem [CDEPTH];
  logic signed [20:0] coef_q;

  logic [BW-1:0]     band;
  logic              ch;
  logic [MW-1:0]     tcnt;

  logic signed [31:0] x, base, t, acc, prod;
  logic signed [31:0] dry_l, dry_r;
  logic signed [16:0] left_res;

  logic               accept, apb_wr, out_free, last_band, last_tick, band_on;
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b, mul_q;
  logic signed [63:0] mul_full;
  sbqeq_pkg::slot_t   rd_slot;
  logic [CAW-1:0]     rd_addr, wr_addr;
  logic               coef_we;
  logic [DKW-1:0]     dk;
  logic [BW-1:0]      tbidx;
  logic [BANDS-1:0]   band_tgt;
  logic [15:0]        glob_tgt, ext_tgt, tcur, ttgt, tnew;
  logic signed [31:0] dry, base_eff, y_glb;
  logic signed [16:0] y_clamp;

  function automatic logic signed [16:0] clamp_one(input logic signed [31:0] y);
    logic signed [16:0] r;
    if (y > 32'sd32768) begin
      r = 17'sd32768;
    end else if (y < -32'sd32768) begin
      r = -17'sd32768;
    end else begin
      r = y[16:0];
    end
    return r;
  endfunction

  assign pready     = 1'b1;
  assign apb_wr     = psel && penable && pwrite && pready;
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign last_band  = (band == BW'(BANDS - 1));
  assign last_tick  = (tcnt == MW'(BANDS + 1));
  assign band_on    = (band_mix[band] != 16'd0);
  assign dk         = DKW'({band, ch});
  assign tbidx      = BW'(tcnt - MW'(2));
  assign dry        = ch ? dry_r : dry_l;
  assign base_eff   = (BASE_BANDS >= BANDS) ? x : base;
  assign y_glb      = dry + prod;
  assign y_clamp    = clamp_one(y_glb);
  assign glob_tgt   = global_bypass ? 16'd0 : sbqeq_pkg::MIX_ONE;
  assign ext_tgt    = extension_bypass ? 16'd0 : sbqeq_pkg::MIX_ONE;
  assign mul_full   = mul_a * mul_b;
  assign mul_q      = mul_full[46:15];
  assign rd_addr    = CAW'(int'(band) * sbqeq_pkg::SLOTS + int'(rd_slot));
  assign wr_addr    = CAW'(int'(coef_band) * sbqeq_pkg::SLOTS + int'(coef_slot));
  assign coef_we    = accept && (cmd == sbqeq_pkg::CMD_COEF) &&
                      (int'(coef_band) < BANDS) &&
                      (int'(coef_slot) < sbqeq_pkg::SLOTS);

  always_comb begin
    for (int i = 0; i < BANDS; i++) begin
      band_tgt[i] = (i < 8) ? band_enable_mask[i[2:0]] : 1'b0;
    end
  end

  always_comb begin
    unique case (tcnt)
      MW'(0): begin
        tcur = glob_mix;
        ttgt = glob_tgt;
      end
      MW'(1): begin
        tcur = ext_mix;
        ttgt = ext_tgt;
      end
      default: begin
        tcur = band_mix[tbidx];
        ttgt = band_tgt[tbidx] ? sbqeq_pkg::MIX_ONE : 16'd0;
      end
    endcase
    if ((prod == 32'sd0) && (tcur != ttgt)) begin
      tnew = ttgt;
    end else begin
      tnew = tcur + prod[15:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sbqeq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (sbqeq_pkg::cmd_t'(cmd))
            sbqeq_pkg::CMD_SAMPLE: state_next = sbqeq_pkg::ST_BAND_CHK;
            sbqeq_pkg::CMD_TICK:   state_next = sbqeq_pkg::ST_TICK_MUL;
            sbqeq_pkg::CMD_COEF,
            sbqeq_pkg::CMD_CLEAR:  state_next = sbqeq_pkg::ST_IDLE;
          endcase
        end
      end
      sbqeq_pkg::ST_TICK_MUL: state_next = sbqeq_pkg::ST_TICK_UPD;
      sbqeq_pkg::ST_TICK_UPD: begin
        state_next = last_tick ? sbqeq_pkg::ST_IDLE : sbqeq_pkg::ST_TICK_MUL;
      end
      sbqeq_pkg::ST_BAND_CHK: begin
        if (band_on) begin
          state_next = sbqeq_pkg::ST_BQ0;
        end else if (last_band) begin
          state_next = sbqeq_pkg::ST_EXT_MUL;
        end
      end
      sbqeq_pkg::ST_BQ0: state_next = sbqeq_pkg::ST_BQ1;
      sbqeq_pkg::ST_BQ1: state_next = sbqeq_pkg::ST_BQ2;
      sbqeq_pkg::ST_BQ2: state_next = sbqeq_pkg::ST_BQ3;
      sbqeq_pkg::ST_BQ3: state_next = sbqeq_pkg::ST_BQ4;
      sbqeq_pkg::ST_BQ4: state_next = sbqeq_pkg::ST_BQ5;
      sbqeq_pkg::ST_BQ5: state_next = sbqeq_pkg::ST_BQ6;
      sbqeq_pkg::ST_BQ6: begin
        state_next = last_band ? sbqeq_pkg::ST_EXT_MUL : sbqeq_pkg::ST_BAND_CHK;
      end
      sbqeq_pkg::ST_EXT_MUL: state_next = sbqeq_pkg::ST_EXT_ADD;
      sbqeq_pkg::ST_EXT_ADD: state_next = sbqeq_pkg::ST_GLB_MUL;
      sbqeq_pkg::ST_GLB_MUL: state_next = sbqeq_pkg::ST_GLB_ADD;
      sbqeq_pkg::ST_GLB_ADD: begin
        if (!ch) begin
          state_next = sbqeq_pkg::ST_BAND_CHK;
        end else if (out_free) begin
          state_next = sbqeq_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    mul_en     = 1'b0;
    mul_a      = x;
    mul_b      = 32'sd0;
    rd_slot    = sbqeq_pkg::SLOT_B0;
    unique case (state)
      sbqeq_pkg::ST_IDLE: item_ready = 1'b1;
      sbqeq_pkg::ST_TICK_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({16'd0, smoothing_factor});
        mul_b  = $signed({16'd0, ttgt}) - $signed({16'd0, tcur});
      end
      sbqeq_pkg::ST_BAND_CHK: rd_slot = sbqeq_pkg::SLOT_B0;
      sbqeq_pkg::ST_BQ0: begin
        mul_en  = 1'b1;
        mul_a   = 32'(coef_q);
        mul_b   = x;
        rd_slot = sbqeq_pkg::SLOT_B1;
      end
      sbqeq_pkg::ST_BQ1: begin
        mul_en  = 1'b1;
        mul_a   = 32'(coef_q);
        mul_b   = x;
        rd_slot = sbqeq_pkg::SLOT_A1;
      end
      sbqeq_pkg::ST_BQ2: begin
        mul_en  = 1'b1;
        mul_a   = 32'(coef_q);
        mul_b   = t;
        rd_slot = sbqeq_pkg::SLOT_B2;
      end
      sbqeq_pkg::ST_BQ3: begin
        mul_en  = 1'b1;
        mul_a   = 32'(coef_q);
        mul_b   = x;
        rd_slot = sbqeq_pkg::SLOT_A2;
      end
      sbqeq_pkg::ST_BQ4: begin
        mul_en = 1'b1;
        mul_a  = 32'(coef_q);
        mul_b  = t;
      end
      sbqeq_pkg::ST_BQ5: begin
        mul_en = 1'b1;
        mul_a  = t - x;
        mul_b  = $signed({16'd0, band_mix[band]});
      end
      sbqeq_pkg::ST_EXT_MUL: begin
        mul_en = 1'b1;
        mul_a  = x - base_eff;
        mul_b  = $signed({16'd0, ext_mix});
      end
      sbqeq_pkg::ST_GLB_MUL: begin
        mul_en = 1'b1;
        mul_a  = x - dry;
        mul_b  = $signed({16'd0, glob_mix});
      end
      sbqeq_pkg::ST_TICK_UPD,
      sbqeq_pkg::ST_BQ6,
      sbqeq_pkg::ST_EXT_ADD,
      sbqeq_pkg::ST_GLB_ADD: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    unique case (sbqeq_pkg::reg_idx_t'(paddr[3:2]))
      sbqeq_pkg::REG_GLOBAL_BYPASS: prdata = {31'd0, global_bypass};
      sbqeq_pkg::REG_EXT_BYPASS:    prdata = {31'd0, extension_bypass};
      sbqeq_pkg::REG_BAND_MASK:     prdata = {24'd0, band_enable_mask};
      sbqeq_pkg::REG_SMOOTHING:     prdata = {16'd0, smoothing_factor};
    endcase
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[wr_addr] <= coef_value;
    end
    coef_q <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= sbqeq_pkg::ST_IDLE;
      band             <= '0;
      ch               <= 1'b0;
      tcnt             <= '0;
      result_valid     <= 1'b0;
      global_bypass    <= 1'b0;
      extension_bypass <= 1'b1;
      band_enable_mask <= 8'd0;
      smoothing_factor <= sbqeq_pkg::SMOOTH_RESET;
      ext_mix          <= 16'd0;
      glob_mix         <= 16'd0;
      for (int i = 0; i < BANDS; i++) begin
        band_mix[i] <= 16'd0;
      end
      for (int i = 0; i < 2 * BANDS; i++) begin
        d1[i] <= 32'sd0;
        d2[i] <= 32'sd0;
      end
    end else begin
      state <= state_next;
      if (apb_wr) begin
        unique case (sbqeq_pkg::reg_idx_t'(paddr[3:2]))
          sbqeq_pkg::REG_GLOBAL_BYPASS: global_bypass <= pwdata[0];
          sbqeq_pkg::REG_EXT_BYPASS:    extension_bypass <= pwdata[0];
          sbqeq_pkg::REG_BAND_MASK:     band_enable_mask <= pwdata[7:0];
          sbqeq_pkg::REG_SMOOTHING: begin
            smoothing_factor <= (pwdata[15:0] > sbqeq_pkg::MIX_ONE) ?
                                sbqeq_pkg::MIX_ONE : pwdata[15:0];
          end
        endcase
      end
      if ((state == sbqeq_pkg::ST_GLB_ADD) && ch && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        sbqeq_pkg::ST_IDLE: begin
          if (accept) begin
            band <= '0;
            ch   <= 1'b0;
            tcnt <= '0;
            if (cmd == sbqeq_pkg::CMD_CLEAR) begin
              for (int i = 0; i < 2 * BANDS; i++) begin
                d1[i] <= 32'sd0;
                d2[i] <= 32'sd0;
              end
              for (int i = 0; i < BANDS; i++) begin
                band_mix[i] <= band_tgt[i] ? sbqeq_pkg::MIX_ONE : 16'd0;
              end
              ext_mix  <= ext_tgt;
              glob_mix <= glob_tgt;
            end
          end
        end
        sbqeq_pkg::ST_TICK_UPD: begin
          unique case (tcnt)
            MW'(0):  glob_mix <= tnew;
            MW'(1):  ext_mix <= tnew;
            default: band_mix[tbidx] <= tnew;
          endcase
          tcnt <= tcnt + MW'(1);
        end
        sbqeq_pkg::ST_BAND_CHK: begin
          if (!band_on && !last_band) begin
            band <= band + BW'(1);
          end
        end
        sbqeq_pkg::ST_BQ3: d1[dk] <= acc - prod + d2[dk];
        sbqeq_pkg::ST_BQ5: d2[dk] <= acc - prod;
        sbqeq_pkg::ST_BQ6: begin
          if (!last_band) begin
            band <= band + BW'(1);
          end
        end
        sbqeq_pkg::ST_GLB_ADD: begin
          if (!ch) begin
            ch   <= 1'b1;
            band <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_q;
    end
    case (state)
      sbqeq_pkg::ST_IDLE: begin
        if (accept && (cmd == sbqeq_pkg::CMD_SAMPLE)) begin
          dry_l <= 32'(left_sample);
          dry_r <= 32'(right_sample);
          x     <= 32'(left_sample);
          base  <= 32'(left_sample);
        end
      end
      sbqeq_pkg::ST_BAND_CHK: begin
        if (int'(band) == BASE_BANDS) begin
          base <= x;
        end
      end
      sbqeq_pkg::ST_BQ1:     t <= prod + d1[dk];
      sbqeq_pkg::ST_BQ2:     acc <= prod;
      sbqeq_pkg::ST_BQ4:     acc <= prod;
      sbqeq_pkg::ST_BQ6:     x <= x + prod;
      sbqeq_pkg::ST_EXT_MUL: base <= base_eff;
      sbqeq_pkg::ST_EXT_ADD: x <= base + prod;
      sbqeq_pkg::ST_GLB_ADD: begin
        if (!ch) begin
          left_res <= y_clamp;
          x        <= dry_r;
          base     <= dry_r;
        end else if (out_free) begin
          left_out  <= left_res;
          right_out <= y_clamp;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_glob_mix_range: assert property (@(posedge clk) disable iff (rst)
    glob_mix <= sbqeq_pkg::MIX_ONE)
    else $error("global mix left its range");

  a_ext_mix_range: assert property (@(posedge clk) disable iff (rst)
    ext_mix <= sbqeq_pkg::MIX_ONE)
    else $error("extension mix left its range");

  a_engaged_band: assert property (@(posedge clk) disable iff (rst)
    (state == sbqeq_pkg::ST_BQ0) |-> (band_mix[band] != 16'd0))
    else $error("biquad run on a band with zero mix");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == sbqeq_pkg::ST_GLB_ADD) && $past(ch))
    else $error("result raised outside the final step of the right channel");
`endif

endmodule
